FILE: design/isbo_pkg.sv
// Shared types and constants of the integer sort core (both orders).
// Used by the front stage, the queue, the back stage and the top level.
package isbo_pkg;

   localparam int MAX_COUNT_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int VALUE_W             = 32;

   // Bit positions inside rsp_tuser.
   localparam int USER_DESC_BIT = 0;
   localparam int USER_OVF_BIT  = 1;
   localparam int USER_W        = 2;

   // One classified input word as it travels from front to back.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      drop;
   } item_type;

   // One result word.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      descending;
      logic                      overflow;
      logic                      last;
   } result_type;

   typedef enum logic [1:0] {
      BACK_LOAD,
      BACK_ASC,
      BACK_DESC
   } back_state_type;

endpackage

FILE: design/isbo_front.sv
// Front stage of the integer sort core: accepts input words and marks those
// beyond capacity for drop. Depends on isbo_pkg.
module isbo_front #(
   parameter int MaxCount = isbo_pkg::MAX_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [isbo_pkg::VALUE_W-1:0] req_tdata,
   input  logic                                req_tlast,
   input  logic                                q_full,
   output logic                                q_push,
   output isbo_pkg::item_type                  q_item
);
   import isbo_pkg::*;

   localparam int CNT_W = $clog2(MaxCount + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             full;

   assign full       = (cnt_ff == CNT_W'(MaxCount));
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item.value = req_tdata;
      q_item.last  = req_tlast;
      q_item.drop  = full;
      cnt_in       = cnt_ff;
      if (q_push) begin
         if (req_tlast) begin
            cnt_in = '0;
         end else if (!full) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: design/isbo_queue.sv
// Short queue between the front and back stages of the integer sort core.
// Depends on isbo_pkg.
module isbo_queue #(
   parameter int Depth = isbo_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  isbo_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output isbo_pkg::item_type pop_item
);
   import isbo_pkg::*;

   localparam int PTR_W  = $clog2(Depth);
   localparam int FILL_W = $clog2(Depth + 1);

   item_type          mem_ff [Depth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_pop;

   assign full     = (fill_ff == FILL_W'(Depth));
   assign valid    = (fill_ff != '0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: design/isbo_back.sv
// Back stage of the integer sort core: insertion row that keeps the list
// sorted as words arrive, and the sequencer that emits it in both orders.
// Depends on isbo_pkg.
module isbo_back #(
   parameter int MaxCount = isbo_pkg::MAX_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  isbo_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output isbo_pkg::result_type rsp_result
);
   import isbo_pkg::*;

   localparam int IDX_W = (MaxCount > 1) ? $clog2(MaxCount) : 1;
   localparam int CNT_W = $clog2(MaxCount + 1);

   back_state_type            state_ff, state_in;
   logic signed [VALUE_W-1:0] row_ff [MaxCount];
   logic signed [VALUE_W-1:0] row_in [MaxCount];
   logic [MaxCount-1:0]       gt;
   logic [CNT_W-1:0]          cnt_ff, cnt_in, last_cnt;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      dropped_ff, dropped_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;
   logic                      out_free, insert;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_cnt   = cnt_ff - CNT_W'(1);

   // Each cell compares the incoming word with its own entry; empty cells
   // count as greater, so the word lands after all entries not above it.
   always_comb begin
      for (int i = 0; i < MaxCount; i++) begin
         gt[i] = (CNT_W'(i) >= cnt_ff) || (q_item.value < row_ff[i]);
      end
      for (int i = 0; i < MaxCount; i++) begin
         row_in[i] = row_ff[i];
         if (gt[i]) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
               row_in[i] = row_ff[(i > 0) ? i - 1 : 0];
            end else begin
               row_in[i] = q_item.value;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      dropped_in   = dropped_ff;
      q_pop        = 1'b0;
      insert       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         BACK_LOAD: begin
            q_pop = q_valid;
            if (q_valid) begin
               if (q_item.drop) begin
                  dropped_in = 1'b1;
               end else begin
                  insert = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (q_item.last) begin
                  state_in = BACK_ASC;
                  idx_in   = '0;
               end
            end
         end
         BACK_ASC: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.value      = row_ff[idx_ff];
               rsp_in.descending = 1'b0;
               rsp_in.overflow   = dropped_ff;
               rsp_in.last       = 1'b0;
               // Hold the index on the top entry: it opens the descending pass.
               if (idx_ff == last_cnt[IDX_W-1:0]) begin
                  state_in = BACK_DESC;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         BACK_DESC: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.value      = row_ff[idx_ff];
               rsp_in.descending = 1'b1;
               rsp_in.overflow   = dropped_ff;
               rsp_in.last       = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in   = BACK_LOAD;
                  cnt_in     = '0;
                  dropped_in = 1'b0;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = BACK_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         for (int i = 0; i < MaxCount; i++) begin
            row_ff[i] <= row_in[i];
         end
      end
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_LOAD;
         cnt_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MaxCount))
      else $error("stored count above capacity");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_ASC || state_ff == BACK_DESC) |-> cnt_ff != '0)
      else $error("emission started on an empty list");
   a_no_pop_while_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BACK_LOAD) |-> !q_pop)
      else $error("queue popped while the list is being emitted");
   a_last_is_desc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> rsp_ff.descending)
      else $error("final word flagged outside the descending pass");
   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result word changed while waiting for the receiver");
`endif

endmodule

FILE: design/integer_sort_both_orders_core.sv
// Top level of the integer sort core: sorts a list of signed 32-bit words
// and returns it ascending, then descending. Depends on isbo_pkg and on
// isbo_front, isbo_queue and isbo_back.
//
// Send the list one word per req_ beat with req_tlast on its final word.
// Each word is placed into a sorted row of MaxCount cells the cycle it
// leaves the front queue, so loading runs at one word per cycle. Words
// past MaxCount in a list are dropped and every result of that list then
// carries the overflow flag. After the final word the back stage emits
// the N stored words in ascending order and then in descending order,
// one rsp_ word per cycle while rsp_tready is high, rsp_tlast on the very
// last one. During the return the sequencer owns the sorted row, so the
// next list fills only the QueueDepth-entry queue before req_tready drops.
// The first word of the next list may follow the previous req_tlast word
// directly. Duplicates are kept. No clearing pass is needed after reset.
module integer_sort_both_orders_core #(
   parameter int MaxCount   = isbo_pkg::MAX_COUNT_DEFAULT,
   parameter int QueueDepth = isbo_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic signed [isbo_pkg::VALUE_W-1:0]  req_tdata,  // [31:0] value
   input  logic                                 req_tlast,  // last
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [isbo_pkg::VALUE_W-1:0]  rsp_tdata,  // [31:0] value_res
   output logic [isbo_pkg::USER_W-1:0]          rsp_tuser,  // [0] descending, [1] overflow
   output logic                                 rsp_tlast   // last_res
);
   import isbo_pkg::*;

   logic       q_push, q_full, q_pop, q_valid;
   item_type   push_item, pop_item;
   result_type result;

   // Classify incoming words: store or drop.
   isbo_front #(
      .MaxCount (MaxCount)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // Decouple the input side from the sequencer.
   isbo_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   // Insert into the sorted row, then emit both orders.
   isbo_back #(
      .MaxCount (MaxCount)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   always_comb begin
      rsp_tdata                = result.value;
      rsp_tuser                = '0;
      rsp_tuser[USER_DESC_BIT] = result.descending;
      rsp_tuser[USER_OVF_BIT]  = result.overflow;
      rsp_tlast                = result.last;
   end

endmodule

FILE: test/tb_top.sv
// Testbench of integer_sort_both_orders_core: streams lists of signed words,
// predicts the ascending and descending return of each list and checks every
// rsp_ word field by field. Depends on isbo_pkg and the core's RTL only.
module tb_top;
   import isbo_pkg::*;

   localparam int LIST_CAP     = MAX_COUNT_DEFAULT;
   localparam int IDLE_LIMIT   = 3000;  // cycles without any handshake
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 24;

   localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic signed [VALUE_W-1:0]  req_tdata  = '0;    // [31:0] value
   logic                       req_tlast  = 1'b0;  // last
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_tdata;          // [31:0] value_res
   logic [USER_W-1:0]          rsp_tuser;          // [0] descending, [1] overflow
   logic                       rsp_tlast;          // last_res

   // Words of the list still open, as the core stores them, and its drop flag.
   logic signed [VALUE_W-1:0]  open_list[$];
   logic                       open_dropped = 1'b0;
   // Sorted words the core still owes us, oldest first.
   result_type                 sorted_words_due[$];

   int mismatch_count  = 0;
   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;
   int hold_ticket     = 0;

   integer_sort_both_orders_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Mostly back to back, sometimes a few cycles, now and then a long pause.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Bias toward the extremes and a narrow band so duplicates show up often.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2, 3: return $urandom_range(0, 16) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Close the open list: sort it ascending (stable insertion, signed) and
   // queue the ascending run, then the descending run ending in last.
   function automatic void sort_open_list();
      logic signed [VALUE_W-1:0] row[$];
      logic signed [VALUE_W-1:0] pick;
      result_type                word;
      int                        j;
      row = open_list;
      for (int i = 1; i < row.size(); i++) begin
         pick = row[i];
         j = i;
         while (j > 0 && pick < row[j-1]) begin
            row[j] = row[j-1];
            j--;
         end
         row[j] = pick;
      end
      for (int i = 0; i < row.size(); i++) begin
         word.value      = row[i];
         word.descending = 1'b0;
         word.overflow   = open_dropped;
         word.last       = 1'b0;
         sorted_words_due.push_back(word);
      end
      for (int i = row.size() - 1; i >= 0; i--) begin
         word.value      = row[i];
         word.descending = 1'b1;
         word.overflow   = open_dropped;
         word.last       = (i == 0);
         sorted_words_due.push_back(word);
      end
      open_list.delete();
      open_dropped = 1'b0;
   endfunction

   // Store or drop one accepted word, close the list on its last word.
   function automatic void take_word(logic signed [VALUE_W-1:0] value, logic last);
      if (open_list.size() < LIST_CAP) open_list.push_back(value);
      else open_dropped = 1'b1;
      if (last) sort_open_list();
   endfunction

   task automatic flag_mismatch(string what, logic signed [VALUE_W-1:0] got,
                                logic signed [VALUE_W-1:0] want);
      $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Offer one word after an optional gap and hold it until accepted.
   task automatic send_word(logic signed [VALUE_W-1:0] value, logic last);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         // Scramble the idle bus so stale data never looks valid.
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tlast  <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      take_word(value, last);
   endtask

   task automatic send_list(int length);
      for (int i = 0; i < length; i++) send_word(pick_value(), i == length - 1);
   endtask

   // Drop valid and wait for a clock edge so the next burst starts clean.
   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_single_words();
      send_word(WORD_MAX, 1'b1);
      send_word(WORD_MIN, 1'b1);
      send_word(0, 1'b1);
      end_burst();
   endtask

   task automatic test_extremes();
      logic signed [VALUE_W-1:0] words[8];
      words = '{WORD_MIN, WORD_MAX, 0, -1, 1, WORD_MIN, WORD_MAX, -2};
      foreach (words[i]) send_word(words[i], i == 7);
      end_burst();
   endtask

   task automatic test_duplicates_and_order();
      logic signed [VALUE_W-1:0] words[6];
      words = '{7, -7, 7, 7, -7, 0};
      foreach (words[i]) send_word(words[i], i == 5);
      // Already sorted, then reversed.
      send_word(-3, 1'b0);
      send_word(2, 1'b0);
      send_word(9, 1'b1);
      send_word(9, 1'b0);
      send_word(2, 1'b0);
      send_word(-3, 1'b1);
      end_burst();
   endtask

   // Mostly short lists, some long ones, a few that fill the store exactly.
   task automatic test_random_lists(int word_budget);
      int sent;
      int length;
      sent = 0;
      while (sent < word_budget) begin
         case ($urandom_range(0, 9))
            0: length = LIST_CAP;
            1, 2: length = $urandom_range(9, LIST_CAP - 1);
            default: length = $urandom_range(1, 8);
         endcase
         send_list(length);
         sent += length;
      end
      end_burst();
   endtask

   // Fill the store and keep going; the closing word itself is dropped.
   task automatic test_overflow();
      send_list(LIST_CAP + 1);
      send_list(LIST_CAP + $urandom_range(2, 8));
      // Next list must start clean, without the overflow flag.
      send_list($urandom_range(1, 5));
      end_burst();
   endtask

   // Hold the receiver off while lists, two of them full, stream in back to back,
   // so the queue fills and req_tready drops.
   task automatic test_backpressure();
      sender_gaps = 1'b0;
      hold_ticket <= hold_ticket + 1;
      send_list(LIST_CAP);
      send_list(20);
      send_list(LIST_CAP);
      end_burst();
      sender_gaps = 1'b1;
   endtask

   // A stretch at full rate on both sides.
   task automatic test_full_rate();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      test_random_lists(60);
      while (sorted_words_due.size() != 0) @(posedge clock);
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // Compare one accepted rsp_ word with the oldest expectation.
   task automatic check_word();
      result_type want;
      if (sorted_words_due.size() == 0) begin
         flag_mismatch("word with nothing due", rsp_tdata, 0);
      end else begin
         want = sorted_words_due.pop_front();
         if (rsp_tdata !== want.value) flag_mismatch("value", rsp_tdata, want.value);
         if (rsp_tuser[USER_DESC_BIT] !== want.descending)
            flag_mismatch("descending", VALUE_W'(rsp_tuser[USER_DESC_BIT]),
                          VALUE_W'(want.descending));
         if (rsp_tuser[USER_OVF_BIT] !== want.overflow)
            flag_mismatch("overflow", VALUE_W'(rsp_tuser[USER_OVF_BIT]),
                          VALUE_W'(want.overflow));
         if (rsp_tlast !== want.last)
            flag_mismatch("last", VALUE_W'(rsp_tlast), VALUE_W'(want.last));
      end
   endtask

   // Receiver: check each accepted word, then pick the next ready level.
   initial begin : response_sink
      int stall_left;
      int hold_seen;
      stall_left = 0;
      hold_seen  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_word();
         if (hold_ticket != hold_seen) begin
            hold_seen  = hold_ticket;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && receiver_stalls) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run once no word moves on either side for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : run_tests
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_single_words();
      test_extremes();
      test_duplicates_and_order();
      test_random_lists(80);
      test_overflow();
      test_backpressure();
      test_full_rate();
      test_random_lists(40);
      while (sorted_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
